// ===== sv/uosm_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 overlong/surrogate marker package
// Item types, check constants and the sequence check shared by the marker unit.
// ----------------------------------------------------------------------------
package uosm_pkg;

	localparam int unsigned CodeW  = 25;
	localparam int unsigned CountW = 3;

	// Input item: one raw text byte and the end-of-text flag.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_text;
	} raw_item_t;

	// Result item: one output text byte and the end-of-run flag.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} mkd_item_t;

	// Checked item handed from the sequence tracker to the emitter.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       pre_mark;
		logic       post_mark;
	} chk_t;

	localparam logic [CodeW-1:0]  UNICODE_TOP = CodeW'(32'h0010_FFFF);
	localparam logic [CodeW-1:0]  SURR_LOW    = CodeW'(32'h0000_D800);
	localparam logic [CodeW-1:0]  SURR_HIGH   = CodeW'(32'h0000_DFFF);
	localparam logic [CodeW-1:0]  MIN_TWO     = CodeW'(32'd128);
	localparam logic [CodeW-1:0]  MIN_THREE   = CodeW'(32'd2048);
	localparam logic [CodeW-1:0]  MIN_FOUR    = CodeW'(32'd65536);
	localparam logic [CountW-1:0] COUNT_ONE   = CountW'(1);
	localparam logic [CountW-1:0] COUNT_TWO   = CountW'(2);
	localparam logic [CountW-1:0] COUNT_THREE = CountW'(3);
	localparam logic [CountW-1:0] COUNT_FOUR  = CountW'(4);

	// The marker is U+2620, sent as a three-byte sequence.
	localparam logic [15:0] MARK_CODE = 16'h2620;
	localparam logic [7:0]  MARK_B0   = {4'hE, MARK_CODE[15:12]};
	localparam logic [7:0]  MARK_B1   = {2'b10, MARK_CODE[11:6]};
	localparam logic [7:0]  MARK_B2   = {2'b10, MARK_CODE[5:0]};

	// A sequence fails if it is a surrogate, overlong for its length, or
	// beyond the top of the code space.
	function automatic logic seq_fails(input logic [CodeW-1:0] v,
	                                   input logic [CountW-1:0] n);
		logic bad;
		bad = (v >= SURR_LOW) && (v <= SURR_HIGH);
		if (n == COUNT_TWO && v < MIN_TWO) bad = 1'b1;
		if (n == COUNT_THREE && v < MIN_THREE) bad = 1'b1;
		if (n == COUNT_FOUR && (v < MIN_FOUR || v > UNICODE_TOP)) bad = 1'b1;
		return bad;
	endfunction

endpackage

// ===== sv/utf8_overlong_surrogate_marker_unit.sv =====
// ----------------------------------------------------------------------------
// UTF-8 overlong/surrogate marker unit
// Passes a UTF-8 byte stream through and inserts the marker U+2620 after any
// sequence that is overlong, a surrogate or beyond U+10FFFF.
// ----------------------------------------------------------------------------
// The raw channel takes one text byte per item, with end_of_text on the final
// byte of a text. The marked channel gives one output byte per item, and
// last_of_run is set on the final output byte that an input item causes.
// Each input item gives its own byte, preceded by the three marker bytes when
// the sequence it closes fails the check, and followed by them when
// end_of_text is set and the sequence standing after the byte fails.
// An input item is registered in the emitter at the edge where it is accepted,
// and its bytes then pass through the output register, which sends one byte
// per cycle while the receiver does not stall; a clean item gives one byte,
// an item with one marker four bytes and an item with both markers seven.
// The emitter stage is the only limit: raw_stall stays high while it still
// holds bytes of the current item that the output register has not taken.
// When the receiver stalls, the output item holds and the emitter waits, and
// once the emitter is full the raw channel is stalled in turn.
// Reset clears the sequence state to an empty sequence and empties both the
// emitter and the output register; an end-of-text item does the same to the
// sequence state after its final check.
// ----------------------------------------------------------------------------
module utf8_overlong_surrogate_marker_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                raw_valid,
	output logic                raw_stall,
	input  uosm_pkg::raw_item_t raw_item,
	output logic                mkd_valid,
	input  logic                mkd_stall,
	output uosm_pkg::mkd_item_t mkd_item
);
	import uosm_pkg::*;

	chk_t chk;
	logic raw_accept;

	// The tracker updates its sequence state on exactly the edges where the
	// emitter takes the item.
	assign raw_accept = raw_valid && !raw_stall;

	uosm_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (raw_accept),
		.item   (raw_item),
		.chk    (chk)
	);

	uosm_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (raw_valid),
		.stall     (raw_stall),
		.chk       (chk),
		.mkd_valid (mkd_valid),
		.mkd_stall (mkd_stall),
		.mkd_item  (mkd_item)
	);

endmodule

// ===== sv/uosm_track.sv =====
// ----------------------------------------------------------------------------
// UTF-8 sequence tracker
// Holds the code value and byte count of the current sequence and flags the
// items that need a marker before or after their byte.
// ----------------------------------------------------------------------------
module uosm_track (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  uosm_pkg::raw_item_t item,
	output uosm_pkg::chk_t      chk
);
	import uosm_pkg::*;

	logic [CodeW-1:0]  code_value_q;
	logic [CountW-1:0] seq_byte_count_q;
	logic [CodeW-1:0]  next_value;
	logic [CountW-1:0] next_count;
	logic [7:0]        b;
	logic              ends_seq;

	assign b = item.data_byte;

	always_comb begin
		next_value = code_value_q;
		next_count = seq_byte_count_q;
		ends_seq   = 1'b0;
		if (b[7:6] == 2'b11) begin
			// Lead byte: keep the payload bits that its length leaves.
			ends_seq   = 1'b1;
			next_count = COUNT_ONE;
			if (!b[5]) begin
				next_value = CodeW'(b[4:0]);
			end else if (!b[4]) begin
				next_value = CodeW'(b[3:0]);
			end else if (!b[3]) begin
				next_value = CodeW'(b[2:0]);
			end else begin
				next_value = '0;
			end
		end else if (b[7]) begin
			// Continuation byte: a full sequence absorbs further ones unchanged.
			if (seq_byte_count_q < COUNT_FOUR) begin
				next_count = seq_byte_count_q + COUNT_ONE;
				next_value = {code_value_q[CodeW-7:0], b[5:0]};
			end
		end else begin
			ends_seq   = 1'b1;
			next_count = COUNT_ONE;
			next_value = CodeW'(b);
		end
	end

	assign chk.data_byte = b;
	assign chk.pre_mark  = ends_seq && seq_fails(code_value_q, seq_byte_count_q);
	assign chk.post_mark = item.end_of_text && seq_fails(next_value, next_count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_value_q     <= '0;
			seq_byte_count_q <= '0;
		end else if (accept) begin
			if (item.end_of_text) begin
				code_value_q     <= '0;
				seq_byte_count_q <= '0;
			end else begin
				code_value_q     <= next_value;
				seq_byte_count_q <= next_count;
			end
		end
	end

endmodule

// ===== sv/uosm_emit.sv =====
// ----------------------------------------------------------------------------
// Marker emitter
// Holds one checked item and sends its bytes, with any markers, through the
// output register one byte per cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
module uosm_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	output logic                stall,
	input  uosm_pkg::chk_t      chk,
	output logic                mkd_valid,
	input  logic                mkd_stall,
	output uosm_pkg::mkd_item_t mkd_item
);
	import uosm_pkg::*;

	// Byte positions within one item: leading marker, the byte, trailing marker.
	typedef enum logic [2:0] {
		PH_PRE0  = 3'd0,
		PH_PRE1  = 3'd1,
		PH_PRE2  = 3'd2,
		PH_BYTE  = 3'd3,
		PH_POST0 = 3'd4,
		PH_POST1 = 3'd5,
		PH_POST2 = 3'd6
	} phase_t;

	chk_t       item_s1;
	logic       valid_s1;
	phase_t     phase_q;
	mkd_item_t  out_s2;
	logic       valid_s2;
	logic       out_free;
	logic       load;
	logic       last_phase;
	logic       done;
	logic       accept;
	logic [7:0] cur_byte;

	assign out_free   = !valid_s2 || !mkd_stall;
	assign load       = valid_s1 && out_free;
	assign last_phase = (phase_q == (item_s1.post_mark ? PH_POST2 : PH_BYTE));
	assign done       = load && last_phase;
	assign stall      = valid_s1 && !done;
	assign accept     = valid && !stall;

	always_comb begin
		case (phase_q)
			PH_PRE0, PH_POST0: cur_byte = MARK_B0;
			PH_PRE1, PH_POST1: cur_byte = MARK_B1;
			PH_PRE2, PH_POST2: cur_byte = MARK_B2;
			default:           cur_byte = item_s1.data_byte;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_BYTE;
			item_s1  <= '0;
			valid_s2 <= 1'b0;
			out_s2   <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				item_s1  <= chk;
				phase_q  <= chk.pre_mark ? PH_PRE0 : PH_BYTE;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end else if (load) begin
				phase_q <= phase_t'(phase_q + 3'd1);
			end
			if (out_free) begin
				valid_s2 <= load;
			end
			if (load) begin
				out_s2.out_byte    <= cur_byte;
				out_s2.last_of_run <= last_phase;
			end
		end
	end

	assign mkd_valid = valid_s2;
	assign mkd_item  = out_s2;

endmodule

// ===== sv/uosm_checker.sv =====
// ----------------------------------------------------------------------------
// Marker unit checker
// Port-level checks on buffering, reset and the output handshake.
// ----------------------------------------------------------------------------
module uosm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                raw_valid,
	input logic                raw_stall,
	input uosm_pkg::raw_item_t raw_item,
	input logic                mkd_valid,
	input logic                mkd_stall,
	input uosm_pkg::mkd_item_t mkd_item
);
	import uosm_pkg::*;

	logic [1:0] pending_q;
	logic       raw_take;
	logic       run_end;

	assign raw_take = raw_valid && !raw_stall;
	assign run_end  = mkd_valid && !mkd_stall && mkd_item.last_of_run;

	// Items accepted whose final output byte has not yet been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else begin
			pending_q <= pending_q + {1'b0, raw_take} - {1'b0, run_end};
		end
	end

	// Checked at the edge after, so that the output register has seen a reset edge.
	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !mkd_valid)
		else $error("output valid after a reset edge");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mkd_valid && mkd_stall |=> mkd_valid && $stable(mkd_item))
		else $error("stalled output item changed");

	a_two_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two items in flight");

	a_no_spare_end: assert property (@(posedge clk) disable iff (!arst_n)
		run_end |-> pending_q != 2'd0)
		else $error("end of run without an accepted item");

	a_data_known: assert property (@(posedge clk) disable iff (!arst_n)
		raw_take |-> !$isunknown(raw_item.end_of_text))
		else $error("end_of_text unknown on an accepted item");

endmodule

bind utf8_overlong_surrogate_marker_unit uosm_checker u_uosm_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the UTF-8 overlong/surrogate marker unit
// Feeds raw text bytes through a valid/stall driver, forecasts every output
// byte with an independent model of the sequence tracker, and compares the
// marked stream byte by byte while both sides idle and stall in phases.
// ----------------------------------------------------------------------------
module tb_top;
	import uosm_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 5;
	localparam int TEXT_ITEMS   = 470;
	localparam int PHASE_LEN    = 40;
	localparam int HOLD_AT      = 200;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 4000;
	localparam int TAIL_CYCLES  = 8;

	// Idling phases, stepped through as the input count grows.
	typedef enum int {
		PH_FLOWING  = 0,
		PH_SENDER   = 1,
		PH_RECEIVER = 2,
		PH_BOTH     = 3
	} idle_phase_e;

	// Limits of the sequence check and the marker bytes used by the forecast.
	localparam logic [24:0] TOP_CODE   = 25'h010_FFFF;
	localparam logic [24:0] SURR_FIRST = 25'h000_D800;
	localparam logic [24:0] SURR_LAST  = 25'h000_DFFF;
	localparam logic [15:0] MARKER_CP  = 16'h2620;
	localparam logic [7:0]  MARKER_1ST = {4'hE, MARKER_CP[15:12]};
	localparam logic [7:0]  MARKER_2ND = {2'b10, MARKER_CP[11:6]};
	localparam logic [7:0]  MARKER_3RD = {2'b10, MARKER_CP[5:0]};

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      raw_valid = 1'b0;
	logic      mkd_stall = 1'b0;
	raw_item_t raw_item  = '0;
	logic      raw_stall;
	logic      mkd_valid;
	mkd_item_t mkd_item;

	utf8_overlong_surrogate_marker_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw_valid (raw_valid),
		.raw_stall (raw_stall),
		.raw_item  (raw_item),
		.mkd_valid (mkd_valid),
		.mkd_stall (mkd_stall),
		.mkd_item  (mkd_item)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Text bytes still to be offered, and output bytes forecast but not yet seen.
	raw_item_t   text_backlog[$];
	mkd_item_t   marked_due[$];

	// Forecast copy of the tracker state.
	logic [24:0] fc_code  = '0;
	logic [2:0]  fc_count = '0;

	logic raw_taken    = 1'b0;
	int   raw_count    = 0;
	int   out_count    = 0;
	int   marks_due    = 0;
	int   eot_count    = 0;
	int   fail_count   = 0;
	int   quiet_cycles = 0;
	int   hold_left    = 0;
	bit   hold_done    = 1'b0;

	// ------------------------------------------------------------------------
	// Forecasting
	// ------------------------------------------------------------------------

	// A finished sequence is refused when it is a surrogate, when it is longer
	// than its value needs, or when a four-byte form lands beyond the top of
	// the code space. Counts of 0 and 1 only ever face the surrogate test.
	function automatic bit seq_is_broken(input logic [24:0] v, input logic [2:0] n);
		bit bad;
		bad = (v >= SURR_FIRST) && (v <= SURR_LAST);
		if (n == 3'd2 && v < 25'd128)
			bad = 1'b1;
		if (n == 3'd3 && v < 25'd2048)
			bad = 1'b1;
		if (n == 3'd4 && (v < 25'd65536 || v > TOP_CODE))
			bad = 1'b1;
		return bad;
	endfunction

	// Works out every output byte that one accepted text byte causes, in
	// order, and appends them to the queue of bytes still due.
	task automatic forecast_marked(input raw_item_t it);
		mkd_item_t   run[7];
		int          k;
		logic [7:0]  b;
		logic [24:0] old_code;
		logic [2:0]  old_count;
		bit          closes;
		k         = 0;
		b         = it.data_byte;
		old_code  = fc_code;
		old_count = fc_count;
		closes    = 1'b0;
		if (b >= 8'hC0) begin
			// Lead byte: keep only its payload bits, none for F8 and above.
			if (b >= 8'hF8)
				fc_code = '0;
			else if (b >= 8'hF0)
				fc_code = 25'(b[2:0]);
			else if (b >= 8'hE0)
				fc_code = 25'(b[3:0]);
			else
				fc_code = 25'(b[4:0]);
			fc_count = 3'd1;
			closes   = 1'b1;
		end else if (b >= 8'h80) begin
			// Continuation byte: once four bytes are in, further ones are absorbed.
			if (fc_count < 3'd4) begin
				fc_count = fc_count + 3'd1;
				fc_code  = {fc_code[18:0], b[5:0]};
			end
		end else begin
			fc_code  = 25'(b);
			fc_count = 3'd1;
			closes   = 1'b1;
		end
		if (closes && seq_is_broken(old_code, old_count)) begin
			run[k]   = '{out_byte: MARKER_1ST, last_of_run: 1'b0};
			run[k+1] = '{out_byte: MARKER_2ND, last_of_run: 1'b0};
			run[k+2] = '{out_byte: MARKER_3RD, last_of_run: 1'b0};
			k += 3;
			marks_due++;
		end
		run[k] = '{out_byte: b, last_of_run: 1'b0};
		k++;
		if (it.end_of_text) begin
			// The sequence left standing after the final byte gets its own check.
			if (seq_is_broken(fc_code, fc_count)) begin
				run[k]   = '{out_byte: MARKER_1ST, last_of_run: 1'b0};
				run[k+1] = '{out_byte: MARKER_2ND, last_of_run: 1'b0};
				run[k+2] = '{out_byte: MARKER_3RD, last_of_run: 1'b0};
				k += 3;
				marks_due++;
			end
			fc_code  = '0;
			fc_count = '0;
			eot_count++;
		end
		run[k-1].last_of_run = 1'b1;
		for (int i = 0; i < k; i++)
			marked_due.push_back(run[i]);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	task automatic queue_text_byte(input logic [7:0] b, input bit eot);
		raw_item_t it;
		it.data_byte   = b;
		it.end_of_text = eot;
		text_backlog.push_back(it);
	endtask

	// Encodes a code value in the given length and queues the first 'keep'
	// bytes; fewer than 'len' gives a truncated sequence. The end-of-text flag
	// goes on the last byte queued.
	task automatic queue_code(input logic [20:0] cp, input int len, input int keep,
	                          input bit eot);
		logic [7:0] seq[4];
		seq = '{default: 8'h00};
		case (len)
			1: begin
				seq[0] = {1'b0, cp[6:0]};
			end
			2: begin
				seq[0] = {3'b110, cp[10:6]};
				seq[1] = {2'b10, cp[5:0]};
			end
			3: begin
				seq[0] = {4'b1110, cp[15:12]};
				seq[1] = {2'b10, cp[11:6]};
				seq[2] = {2'b10, cp[5:0]};
			end
			default: begin
				seq[0] = {5'b11110, cp[20:18]};
				seq[1] = {2'b10, cp[17:12]};
				seq[2] = {2'b10, cp[11:6]};
				seq[3] = {2'b10, cp[5:0]};
			end
		endcase
		for (int i = 0; i < keep; i++)
			queue_text_byte(seq[i], eot && (i == keep - 1));
	endtask

	function automatic idle_phase_e current_phase();
		return idle_phase_e'((raw_count / PHASE_LEN) % 4);
	endfunction

	// The sender never rests during the long receiver hold-off, so that the
	// unit fills up and has to stall its input.
	function automatic bit sender_rests();
		if (hold_left > 0)
			return 1'b0;
		case (current_phase())
			PH_SENDER: return $urandom_range(0, 99) < 80;
			PH_BOTH:   return $urandom_range(0, 99) < 6;
			default:   return 1'b0;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Driver: moves on at the falling edge once the current item has gone.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && (!raw_valid || raw_taken)) begin
			if (text_backlog.size() != 0 && !sender_rests()) begin
				raw_item  <= text_backlog.pop_front();
				raw_valid <= 1'b1;
			end else begin
				// Idle cycles carry junk on the payload; it must be ignored.
				raw_item  <= raw_item_t'(9'($urandom));
				raw_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver pacing: phase-driven stalls plus one long hold-off, counted here.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin : rx_pacing
		logic stall_next;
		int   hold_next;
		hold_next = hold_left;
		if (!hold_done && raw_count >= HOLD_AT) begin
			hold_next  = HOLD_CYCLES;
			hold_done <= 1'b1;
		end
		if (hold_next > 0) begin
			stall_next = 1'b1;
			hold_next  = hold_next - 1;
		end else begin
			case (current_phase())
				PH_RECEIVER: stall_next = $urandom_range(0, 99) < 80;
				PH_BOTH:     stall_next = $urandom_range(0, 99) < 6;
				default:     stall_next = 1'b0;
			endcase
		end
		hold_left <= hold_next;
		mkd_stall <= stall_next;
	end

	// ------------------------------------------------------------------------
	// Monitor: forecasts on each accepted input and checks each accepted output.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : watch_ports
		mkd_item_t due;
		raw_taken <= arst_n && raw_valid && !raw_stall;
		if (arst_n) begin
			if (raw_valid && !raw_stall) begin
				forecast_marked(raw_item);
				raw_count <= raw_count + 1;
			end
			if (mkd_valid && !mkd_stall) begin
				out_count <= out_count + 1;
				if (marked_due.size() == 0) begin
					$display("%0t: unexpected output byte %02h last %0b, nothing due",
					         $time, mkd_item.out_byte, mkd_item.last_of_run);
					fail_count++;
				end else begin
					due = marked_due.pop_front();
					if (mkd_item.out_byte !== due.out_byte) begin
						$display("%0t: out_byte expected %02h, got %02h",
						         $time, due.out_byte, mkd_item.out_byte);
						fail_count++;
					end
					if (mkd_item.last_of_run !== due.last_of_run) begin
						$display("%0t: last_of_run expected %0b, got %0b (byte %02h)",
						         $time, due.last_of_run, mkd_item.last_of_run,
						         mkd_item.out_byte);
						fail_count++;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: ends the run if neither channel moves for too long.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((raw_valid && !raw_stall) || (mkd_valid && !mkd_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d bytes still due",
				         $time, quiet_cycles, marked_due.size());
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin : main_flow
		int          pick;
		int          len;
		int          reps;
		bit          eot_here;
		logic [20:0] cp;

		// Directed text: ASCII extremes, an overlong two-byte form closed by a
		// lead byte, an overlong three-byte form, a surrogate, a value beyond
		// U+10FFFF, a lead from F8 upwards followed by more continuations than
		// fit, a truncated sequence closed by ASCII, a surrogate caught by the
		// end-of-text check, and a continuation straight after that reset.
		queue_text_byte(8'h00, 1'b0);
		queue_text_byte(8'h7F, 1'b0);
		queue_code(21'h00_0000, 2, 2, 1'b0);
		queue_code(21'h00_07FF, 3, 3, 1'b0);
		queue_code(21'h00_D800, 3, 3, 1'b0);
		queue_code(21'h11_0000, 4, 4, 1'b0);
		queue_text_byte(8'hFF, 1'b0);
		for (int i = 0; i < 5; i++)
			queue_text_byte(8'h80, 1'b0);
		queue_code(21'h00_2620, 3, 2, 1'b0);
		queue_text_byte(8'h41, 1'b0);
		queue_code(21'h00_DFFF, 3, 3, 1'b1);
		queue_text_byte(8'hBF, 1'b1);

		// Random text: mostly well-formed sequences with random values, the
		// rest broken forms and plain noise.
		while (text_backlog.size() < TEXT_ITEMS) begin
			pick     = $urandom_range(0, 99);
			eot_here = ($urandom_range(0, 15) == 0);
			if (pick < 60) begin
				len = $urandom_range(1, 4);
				case (len)
					1: cp = 21'($urandom_range(0, 127));
					2: cp = 21'($urandom_range(128, 2047));
					3: begin
						cp = 21'($urandom_range(2048, 16'hFFFF));
						if (cp >= 21'h00_D800 && cp <= 21'h00_DFFF)
							cp = cp - 21'h00_1000;
					end
					default: cp = 21'($urandom_range(21'h01_0000, 21'h10_FFFF));
				endcase
				queue_code(cp, len, len, eot_here);
			end else if (pick < 68) begin
				// Overlong: a value that would fit a shorter form.
				len = $urandom_range(2, 4);
				cp  = 21'($urandom_range(0, (len == 2) ? 127 : (len == 3) ? 2047 : 65535));
				queue_code(cp, len, len, eot_here);
			end else if (pick < 73) begin
				cp = 21'($urandom_range(21'h00_D800, 21'h00_DFFF));
				queue_code(cp, 3, 3, eot_here);
			end else if (pick < 78) begin
				cp = 21'($urandom_range(21'h11_0000, 21'h1F_FFFF));
				queue_code(cp, 4, 4, eot_here);
			end else if (pick < 86) begin
				len = $urandom_range(2, 4);
				cp  = 21'($urandom_range(0, 21'h1F_FFFF));
				queue_code(cp, len, $urandom_range(1, len - 1), eot_here);
			end else if (pick < 92) begin
				reps = $urandom_range(1, 6);
				for (int i = 0; i < reps; i++)
					queue_text_byte(8'($urandom_range(8'h80, 8'hBF)),
					                eot_here && (i == reps - 1));
			end else if (pick < 96) begin
				queue_text_byte(8'($urandom_range(0, 255)), eot_here);
			end else begin
				reps = $urandom_range(0, 5);
				queue_text_byte(8'($urandom_range(8'hF8, 8'hFF)), eot_here && (reps == 0));
				for (int i = 0; i < reps; i++)
					queue_text_byte(8'($urandom_range(8'h80, 8'hBF)),
					                eot_here && (i == reps - 1));
			end
		end

		// Reset is held low from the start and released at a falling edge, away from the rising edge.
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for the last item to be taken, then for every due byte to arrive,
		// then a tail in which any stray output would still be caught.
		while (text_backlog.size() != 0 || raw_valid)
			@(posedge clk);
		while (marked_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d text bytes (%0d ending a text) giving %0d output bytes,",
		         raw_count, eot_count, out_count);
		$display("with %0d markers inserted and one %0d-cycle receiver hold-off.",
		         marks_due, HOLD_CYCLES);
		if (fail_count == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("%0d mismatches in total", fail_count);
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
